### rtl/core/sorted_list_priority_queue_core_macros.svh
// Assertion macros for the sorted-list priority queue core.
// Used by sorted_list_priority_queue_core; needs a clk and rst in scope.
`ifndef SORTED_LIST_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_LIST_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slpq assertion failed");

// Next-cycle implication, disabled during reset.
`define SLPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slpq assertion failed");

`endif

### rtl/core/slpq_pkg.sv
// Package for the sorted-list priority queue: item types, codes, defaults.
// No dependencies.
`default_nettype none

package slpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VAL_W        = 32;
  localparam int CNT_OUT_W    = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] value;
  } slpq_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic [CNT_OUT_W-1:0]    count;
    logic                    is_empty;
    logic [1:0]              error;
  } slpq_rsp_t;

  // Broadcast to every cell: which update applies this cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } slpq_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/slpq_cell.sv
// One storage cell of the sorted-list queue: holds one entry, compares it
// against the incoming value and shifts with its neighbors. Uses slpq_pkg.
`default_nettype none

module slpq_cell
  import slpq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                    clk,
  input  wire slpq_ctrl_t              ctrl,
  input  wire logic signed [VAL_W-1:0] new_val,
  input  wire logic [CNT_W-1:0]        held,
  input  wire logic signed [VAL_W-1:0] left_val,
  input  wire logic                    left_gt,
  input  wire logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0]      val,
  output logic                         gt
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic occ;

  // gt: the new value belongs in front of this entry
  assign occ = held > IDX_C;
  assign gt  = occ && (new_val < val);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt || (held == IDX_C)) begin
        val <= new_val;
      end
    end else if (ctrl.rem) begin
      val <= right_val;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sorted_list_priority_queue_core.sv
// Top level of the sorted-list min-priority queue: control, count and the
// row of slpq_cell entries. Uses slpq_pkg and the assertion macro header.
`default_nettype none
`include "sorted_list_priority_queue_core_macros.svh"

// Usage
// - Command channel: an item (req.cmd, req.value) is taken on a rising edge
//   with start high and busy low. busy is held low: an item may be issued in
//   every cycle.
// - Result channel: done pulses for one cycle, the cycle after the item was
//   taken, with rsp carrying the new minimum, the entry count, an empty flag
//   and an error code. The receiver cannot hold results off.
// - Throughput is one item per cycle. Every cell compares against the new
//   value in parallel and shifts by one position, so the step time is one
//   compare plus a small select per cell (hold, left neighbor, new value or
//   right neighbor).
// - Entries sit sorted ascending in cell 0 upward; cell 0 is the minimum.
//   Equal values keep arrival order (an insert lands behind equal entries).
// - An insert into a full queue is dropped with ERR_FULL; a removal from an
//   empty queue does nothing and reports ERR_EMPTY.
// - Reset clears the count and the strobe; cell contents are not cleared
//   and cells at or above the count are never reported.
// - count carries the low five bits of the entry count.

module sorted_list_priority_queue_core
  import slpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire slpq_req_t req,
  output logic           busy,
  output logic           done,
  output slpq_rsp_t      rsp
);

  localparam int               CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // held entry count and next value
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic [1:0]       err;
  logic [1:0]       err_next;

  logic       accept;
  logic       full;
  logic       empty;
  slpq_ctrl_t ctrl;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (held == CAP_C);
  assign empty  = (held == '0);

  // Decode the command into the update broadcast to the cells.
  always_comb begin
    ctrl      = '0;
    held_next = held;
    err_next  = ERR_OK;
    if (accept) begin
      unique case (req.cmd)
        CMD_INSERT: begin
          if (full) begin
            err_next = ERR_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            held_next = held + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (empty) begin
            err_next = ERR_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            held_next = held - CNT_W'(1);
          end
        end
        default: begin
          err_next = ERR_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      done <= 1'b0;
    end else begin
      held <= held_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_next;
    end
  end

  // Row of cells. Cell 0 has no left neighbor; the last cell has no right
  // neighbor and just keeps its value on a remove (it is beyond the count).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] lv;
    logic                    lg;
    logic signed [VAL_W-1:0] rv;

    if (i == 0) begin : g_first
      assign lv = cell_val[i];
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    slpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (req.value),
      .held      (held),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  // Result is read straight from state: it holds until the next accepted item.
  assign rsp.min_value = empty ? '0 : cell_val[0];
  assign rsp.count     = CNT_OUT_W'(held);
  assign rsp.is_empty  = empty;
  assign rsp.error     = err;

  // Every accepted item yields a result on the next cycle.
  `SLPQ_ASSERT_NEXT(a_item_result, accept, done)
  // Count never exceeds capacity.
  `SLPQ_ASSERT_NOW(a_count_bound, 1'b1, held <= CAP_C)
  // A dropped insert leaves the queue full.
  `SLPQ_ASSERT_NOW(a_full_drop, done && (rsp.error == ERR_FULL), full)
  // The two front entries stay in order.
  `SLPQ_ASSERT_NOW(a_front_sorted, held >= CNT_W'(2), cell_val[0] <= cell_val[1])

endmodule

`default_nettype wire

### verif/sorted_list_priority_queue_core_tb.sv
// Self-checking testbench for sorted_list_priority_queue_core: directed and random
// insert/remove traffic against a behavioral queue predictor. Needs slpq_pkg and the RTL.
`timescale 1ns / 100ps

module sorted_list_priority_queue_core_tb
  import slpq_pkg::*;
;

  localparam int QCAP = DEF_CAPACITY;
  localparam int CLK_PERIOD = 12;
  localparam int RST_CYCLES = 10;
  // Worst case is roughly 800 items at the longest pick_gap gap each; leave a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS = 30;
  localparam int SETTLE_CYCLES = 4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk;
  logic      rst;
  logic      start;
  slpq_req_t req;
  logic      busy;
  logic      done;
  slpq_rsp_t rsp;

  sorted_list_priority_queue_core #(
    .CAPACITY(QCAP)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // Predictor state: entries kept sorted ascending, index 0 is the minimum.
  logic signed [VAL_W-1:0] model_entries[$];
  // One status item per accepted command, oldest first.
  slpq_rsp_t expected_status_q[$];

  int  mismatch_cnt;
  int  cycle_cnt;
  int  result_cnt;
  // Gaps between items on or off; off gives back-to-back bursts.
  bit  idle_en;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sorted_list_priority_queue_core_tb: FAIL");
      $finish;
    end
  end

  // Apply one command to the predictor and return the status the block
  // should report for it.
  function automatic slpq_rsp_t queue_step(input logic cmd,
                                           input logic signed [VAL_W-1:0] value);
    slpq_rsp_t   status;
    int unsigned pos;
    int unsigned n;
    status = '0;
    status.error = ERR_OK;
    if (cmd == CMD_INSERT) begin
      if (model_entries.size() >= QCAP) begin
        // full: value dropped, nothing moves
        status.error = ERR_FULL;
      end else begin
        // land behind every entry <= value so equal values keep arrival order
        pos = 0;
        while (pos < model_entries.size() && !(value < model_entries[pos])) pos++;
        model_entries.insert(pos, value);
      end
    end else begin
      if (model_entries.size() == 0) begin
        status.error = ERR_EMPTY;
      end else begin
        model_entries.delete(0);
      end
    end
    n = model_entries.size();
    status.min_value = (n != 0) ? model_entries[0] : '0;
    status.count     = n[CNT_OUT_W-1:0];
    status.is_empty  = (n == 0);
    return status;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Values: a mix of extremes, a narrow band (lots of duplicates) and full range.
  function automatic logic signed [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("[%0t] mismatch on result %0d: %s got %h want %h",
               $realtime, result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Drive one command and hold it until the block takes it. start is left
  // high so the next call can follow without a bubble.
  task automatic send_item(input logic cmd, input logic signed [VAL_W-1:0] value);
    int        gap;
    slpq_req_t item;
    gap = idle_en ? pick_gap() : 0;
    item.cmd   = cmd;
    item.value = value;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy !== 1'b0);
    expected_status_q.push_back(queue_step(cmd, value));
  endtask

  // Stop sending and let every outstanding status come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  // Result checker: one status per done pulse, in command order.
  always @(posedge clk) begin : check_results
    slpq_rsp_t want;
    if (!rst && done) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected result, min_value", rsp.min_value, '0);
      end else begin
        want = expected_status_q[0];
        expected_status_q.delete(0);
        if (rsp.min_value !== want.min_value)
          report_mismatch("min_value", rsp.min_value, want.min_value);
        if (rsp.count !== want.count)
          report_mismatch("count", rsp.count, want.count);
        if (rsp.is_empty !== want.is_empty)
          report_mismatch("is_empty", rsp.is_empty, want.is_empty);
        if (rsp.error !== want.error)
          report_mismatch("error", rsp.error, want.error);
      end
      result_cnt <= result_cnt + 1;
    end
  end

  // Extremes, duplicates, removes on empty, value ignored on remove.
  task automatic test_directed();
    send_item(CMD_REMOVE, VAL_MAX);   // remove on empty, nonzero value ignored
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 1);
    send_item(CMD_INSERT, '0);        // duplicate of a held value
    send_item(CMD_INSERT, VAL_MIN);   // duplicate of the minimum
    repeat (7) send_item(CMD_REMOVE, $urandom);
    send_item(CMD_REMOVE, VAL_MIN);   // remove on empty, queue already drained
    send_item(CMD_REMOVE, '0);        // empty again
    send_item(CMD_INSERT, -5);
    send_item(CMD_REMOVE, VAL_MIN);
    wait_for_results();
  endtask

  // Fill to capacity, push a few past full, drain, and poke the empty queue.
  task automatic test_fill_and_overflow(input int rounds);
    int extra;
    for (int r = 0; r < rounds; r++) begin
      while (model_entries.size() < QCAP) send_item(CMD_INSERT, rand_value());
      extra = $urandom_range(1, 3);
      repeat (extra) send_item(CMD_INSERT, rand_value());
      while (model_entries.size() > 0) send_item(CMD_REMOVE, $urandom);
      extra = $urandom_range(1, 2);
      repeat (extra) send_item(CMD_REMOVE, $urandom);
    end
    wait_for_results();
  endtask

  // Even mix of inserts and removes; blocks of 50 either idle or burst.
  task automatic test_random_mix(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) idle_en = ($urandom_range(0, 2) != 0);
      send_item($urandom_range(0, 1) ? CMD_REMOVE : CMD_INSERT, rand_value());
    end
    idle_en = 1'b1;
    wait_for_results();
  endtask

  // Sawtooth: insert-heavy runs push into full, remove-heavy runs into empty.
  task automatic test_sawtooth(input int waves, input int half_len);
    logic cmd;
    for (int w = 0; w < waves; w++) begin
      for (int i = 0; i < 2 * half_len; i++) begin
        if (i < half_len) cmd = ($urandom_range(0, 99) < 80) ? CMD_INSERT : CMD_REMOVE;
        else              cmd = ($urandom_range(0, 99) < 20) ? CMD_INSERT : CMD_REMOVE;
        send_item(cmd, rand_value());
      end
    end
    wait_for_results();
  endtask

  initial begin
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    result_cnt   = 0;
    idle_en      = 1'b1;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_overflow(5);
    test_random_mix(300);
    test_sawtooth(3, 40);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_status_q.size() == 0) begin
      $display("sorted_list_priority_queue_core_tb: PASS");
    end else begin
      $display("sorted_list_priority_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule
